// ===== rtl/sfcrc_pkg.sv =====
// Package with constants, types and the CRC step for the start-flag frame synchronizer.
`default_nettype none
package sfcrc_pkg;

	localparam int RING_DEPTH    = 64;
	localparam int FRAME_LENGTH  = 32;
	localparam int HEADER_LENGTH = 4;

	localparam int PTR_W  = $clog2(RING_DEPTH);
	localparam int CNT_W  = $clog2(FRAME_LENGTH);
	localparam int DIST_W = $clog2(RING_DEPTH + FRAME_LENGTH + 1);

	localparam logic [15:0] CRC_SEED         = 16'hFFFF;
	localparam logic [7:0]  START_FLAG_RESET = 8'h7E;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FLAG_RD,
		ST_FLAG_CHK,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_SCAN_RD,
		ST_SCAN_CHK
	} state_t;

	function automatic ptr_t ring_next(input ptr_t pos);
		ptr_t res;
		if (pos == PTR_W'(RING_DEPTH - 1)) begin
			res = '0;
		end else begin
			res = pos + PTR_W'(1);
		end
		return res;
	endfunction

	function automatic logic [DIST_W-1:0] ring_distance(input ptr_t ahead, input ptr_t behind);
		logic [DIST_W-1:0] res;
		if (ahead >= behind) begin
			res = DIST_W'(ahead) - DIST_W'(behind);
		end else begin
			res = DIST_W'(ahead) + DIST_W'(RING_DEPTH) - DIST_W'(behind);
		end
		return res;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] t;
		t = {crc[7:0], crc[15:8]} ^ {8'h00, b};
		t = t ^ {12'h000, t[7:4]};
		t = t ^ {t[3:0], 12'h000} ^ {3'b000, t[7:0], 5'b00000};
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sfcrc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module sfcrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/start_flag_frame_sync_crc16.sv =====
// Top level of the start-flag frame synchronizer with CRC-16-CCITT.
//
// Raw bytes arrive as words on the s_axis channel and are stored in a ring
// RAM at the head. When the head runs a frame length ahead of the tail and
// the tail byte equals the start flag, the frame is sent on m_axis, start
// flag first; the last word has tlast set and carries the CRC-16-CCITT
// (seed 0xFFFF) over the bytes after the header. Then, with or without a
// frame, the tail steps one place and scans forward to the next start flag,
// or up to the head. A byte that does not complete a window passes through
// IDLE and CHECK. A completed window adds FLAG_RD and FLAG_CHK for the flag
// test, EMIT_RD and EMIT_OUT per emitted byte, SCAN_RD and SCAN_CHK per byte
// scanned and SCAN_RD when the scan stops at the head, since the single RAM
// read port is registered. The input is not ready while a window is handled.
// The output word sits in a register, so a new byte is taken while a finished
// word waits; a stalled receiver pauses the emission. Reset clears the
// pointers, the state and the output valid and sets the start flag to 0x7E;
// the RAM contents are not cleared. The user must write the start flag
// through cfg_we and cfg_wdata while the block is idle; it is not enforced.
`default_nettype none
module start_flag_frame_sync_crc16 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // [7:0] frame_byte, [23:8] payload_crc
	output logic             m_axis_tlast   // frame_last
);

	import sfcrc_pkg::*;

	state_t      state_q, state_n;
	ptr_t        head_q, tail_q, pos_q;
	cnt_t        k_q;
	logic [15:0] crc_q;
	logic [7:0]  start_flag_q;
	logic        out_valid_q;
	logic        out_last_q;
	logic [7:0]  out_byte_q;
	logic [15:0] out_crc_q;

	logic        ram_re;
	ptr_t        ram_raddr;
	logic [7:0]  ram_rdata;
	logic        in_accept;
	logic        out_free;
	logic        window_full;
	logic        flag_hit;
	logic        emit_last;
	logic [15:0] crc_next;

	assign in_accept   = s_axis_tvalid && s_axis_tready;
	assign out_free    = !out_valid_q || m_axis_tready;
	assign window_full = ring_distance(head_q, tail_q) == DIST_W'(FRAME_LENGTH);
	assign flag_hit    = ram_rdata == start_flag_q;
	assign emit_last   = k_q == CNT_W'(FRAME_LENGTH - 1);
	assign crc_next    = (32'(k_q) >= HEADER_LENGTH) ? crc_byte(crc_q, ram_rdata) : crc_q;

	sfcrc_ram #(
		.WIDTH(8),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (in_accept),
		.waddr(head_q),
		.wdata(s_axis_tdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_n = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_n = window_full ? ST_FLAG_RD : ST_IDLE;
			end
			ST_FLAG_RD: begin
				state_n = ST_FLAG_CHK;
			end
			ST_FLAG_CHK: begin
				state_n = flag_hit ? ST_EMIT_RD : ST_SCAN_RD;
			end
			ST_EMIT_RD: begin
				state_n = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (out_free) begin
					state_n = emit_last ? ST_SCAN_RD : ST_EMIT_RD;
				end
			end
			ST_SCAN_RD: begin
				state_n = (pos_q == head_q) ? ST_IDLE : ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				state_n = flag_hit ? ST_IDLE : ST_SCAN_RD;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		ram_re        = 1'b0;
		ram_raddr     = pos_q;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_FLAG_RD: begin
				ram_re    = 1'b1;
				ram_raddr = tail_q;
			end
			ST_EMIT_RD: begin
				ram_re = 1'b1;
			end
			ST_SCAN_RD: begin
				ram_re = pos_q != head_q;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			pos_q        <= '0;
			k_q          <= '0;
			crc_q        <= CRC_SEED;
			start_flag_q <= START_FLAG_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				start_flag_q <= cfg_wdata;
			end
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						head_q <= ring_next(head_q);
					end
				end
				ST_CHECK: begin
					pos_q <= tail_q;
					k_q   <= '0;
					crc_q <= CRC_SEED;
				end
				ST_FLAG_CHK: begin
					if (!flag_hit) begin
						pos_q <= ring_next(tail_q);
					end
				end
				ST_EMIT_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						crc_q       <= crc_next;
						k_q         <= k_q + CNT_W'(1);
						pos_q       <= emit_last ? ring_next(tail_q) : ring_next(pos_q);
					end
				end
				ST_SCAN_RD: begin
					if (pos_q == head_q) begin
						tail_q <= head_q;
					end
				end
				ST_SCAN_CHK: begin
					if (flag_hit) begin
						tail_q <= pos_q;
					end else begin
						pos_q <= ring_next(pos_q);
					end
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_OUT && out_free) begin
			out_byte_q <= ram_rdata;
			out_last_q <= emit_last;
			out_crc_q  <= emit_last ? crc_next : 16'h0000;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_crc_q, out_byte_q};
	assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/sfcrc_checker.sv =====
// Port-level checker for the start-flag frame synchronizer, bound to the top level.
`default_nettype none
module sfcrc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);

	// A stalled output word keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// Only the last word of a frame carries a CRC.
	a_crc_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[23:8] == 16'h0000)
		else $error("CRC field set on a word that is not last");

	// Each accepted byte is checked against the window before the next one.
	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted in back-to-back cycles");

	// No input is taken while a frame is still being sent.
	a_in_during_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
		else $error("input ready in the middle of a frame");

endmodule

bind start_flag_frame_sync_crc16 sfcrc_checker u_sfcrc_checker (.*);
`default_nettype wire

// ===== sim/tb_start_flag_frame_sync_crc16.sv =====
// Self-checking testbench for the start-flag frame synchronizer with CRC-16-CCITT.
module tb_start_flag_frame_sync_crc16;
	import sfcrc_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 400;
	localparam int PHASE_WORDS = 26;
	localparam int NUM_PHASES = 5;
	localparam logic [7:0] DIRECTED_BYTES [24] = '{
		8'h00, 8'hFF, START_FLAG_RESET, 8'hFF, 8'h00, START_FLAG_RESET, 8'h80, 8'h01,
		8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h00, 8'h00, 8'hFF, 8'hFF,
		8'h7D, 8'h7F, 8'h5E, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10
	};

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic        frame_last;
		logic [15:0] payload_crc;
	} frame_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] data_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;  // [7:0] frame_byte, [23:8] payload_crc
	logic        m_axis_tlast;  // frame_last

	logic [7:0]  pending_bytes [$];
	frame_word_t expected_words [$];
	int          error_count = 0;
	int          cycle_count = 0;

	logic [7:0]  ring_copy [RING_DEPTH];
	ptr_t        head_pos = '0;
	ptr_t        tail_pos = '0;
	logic [7:0]  flag_value = START_FLAG_RESET;

	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          stall_mode = 0;

	start_flag_frame_sync_crc16 dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever begin
			#4 clk = ~clk;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic ptr_t advance_pos(input ptr_t pos);
		return (int'(pos) == RING_DEPTH - 1) ? ptr_t'(0) : ptr_t'(pos + 1'b1);
	endfunction

	function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		end
		return c;
	endfunction

	// Stores one received byte and queues the frame words that it releases.
	task automatic absorb_byte(input logic [7:0] b);
		frame_word_t w;
		ptr_t        pos;
		logic [15:0] crc;
		int          gap;
		ring_copy[head_pos] = b;
		head_pos = advance_pos(head_pos);
		gap = (head_pos >= tail_pos) ? int'(head_pos) - int'(tail_pos)
			: int'(head_pos) + RING_DEPTH - int'(tail_pos);
		if (gap == FRAME_LENGTH) begin
			if (ring_copy[tail_pos] == flag_value) begin
				crc = CRC_SEED;
				pos = tail_pos;
				for (int k = 0; k < FRAME_LENGTH; k++) begin
					if (k >= HEADER_LENGTH) begin
						crc = crc_ccitt_step(crc, ring_copy[pos]);
					end
					w.frame_byte = ring_copy[pos];
					w.frame_last = (k == FRAME_LENGTH - 1);
					w.payload_crc = w.frame_last ? crc : 16'h0000;
					expected_words.push_back(w);
					pos = advance_pos(pos);
				end
			end
			tail_pos = advance_pos(tail_pos);
			while (tail_pos != head_pos && ring_copy[tail_pos] != flag_value) begin
				tail_pos = advance_pos(tail_pos);
			end
		end
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return flag_value;
		end else if (r == 1) begin
			return 8'h00;
		end else if (r == 2) begin
			return 8'hFF;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly complete frames behind a flag, with noise and cut-off frames in between.
	task automatic queue_phase(input int count);
		int added;
		int r;
		int n;
		added = 0;
		while (added < count) begin
			r = $urandom_range(0, 9);
			if (r < 7) begin
				pending_bytes.push_back(flag_value);
				for (int i = 1; i < FRAME_LENGTH; i++) begin
					pending_bytes.push_back(pick_byte());
				end
				added += FRAME_LENGTH;
			end else if (r < 9) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					pending_bytes.push_back(8'($urandom_range(0, 255)));
				end
				added += n;
			end else begin
				n = $urandom_range(1, 20);
				pending_bytes.push_back(flag_value);
				for (int i = 0; i < n; i++) begin
					pending_bytes.push_back(pick_byte());
				end
				added += n + 1;
			end
		end
	endtask

	task automatic wait_until_idle();
		do begin
			@(negedge clk);
		end while (pending_bytes.size() != 0 || s_axis_tvalid || expected_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_start_flag(input logic [7:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		flag_value = value;
	endtask

	initial begin
		logic [7:0] next_flag;
		for (int i = 0; i < RING_DEPTH; i++) begin
			ring_copy[i] = 8'h00;
		end
		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (DIRECTED_BYTES[i]) begin
			pending_bytes.push_back(DIRECTED_BYTES[i]);
		end
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				wait_until_idle();
				case (ph)
					1: next_flag = 8'h00;
					2: next_flag = 8'hFF;
					3: next_flag = 8'($urandom_range(1, 254));
					default: next_flag = START_FLAG_RESET;
				endcase
				write_start_flag(next_flag);
			end
			queue_phase(PHASE_WORDS);
		end
		wait_until_idle();
		if (expected_words.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, expected_words.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				absorb_byte(s_axis_tdata);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pending_bytes.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
							: $urandom_range(1, 12);
						gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		frame_word_t w;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual byte %h last %b crc %h",
						$time, m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[23:8]);
					error_count++;
				end else begin
					w = expected_words.pop_front();
					if (m_axis_tdata[7:0] !== w.frame_byte) begin
						$display("%0t: frame_byte expected %h actual %h",
							$time, w.frame_byte, m_axis_tdata[7:0]);
						error_count++;
					end
					if (m_axis_tlast !== w.frame_last) begin
						$display("%0t: frame_last expected %b actual %b",
							$time, w.frame_last, m_axis_tlast);
						error_count++;
					end
					if (m_axis_tdata[23:8] !== w.payload_crc) begin
						$display("%0t: payload_crc expected %h actual %h",
							$time, w.payload_crc, m_axis_tdata[23:8]);
						error_count++;
					end
				end
			end
			if (cycle_count % 128 == 0) begin
				stall_mode = $urandom_range(0, 2);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_mode != 0
				&& $urandom_range(0, stall_mode == 1 ? 3 : 9) == 0) begin
				stall_left = $urandom_range(0, stall_mode == 1 ? 2 : 12);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

// ===== files.f =====
rtl/sfcrc_pkg.sv
rtl/sfcrc_ram.sv
rtl/start_flag_frame_sync_crc16.sv
rtl/sfcrc_checker.sv
sim/tb_start_flag_frame_sync_crc16.sv
